FILE: rtl/tbrl_pkg.sv
// Shared types and constants for the tick budget rate limiter.
// Used by every module of the block and by its port checker.
`timescale 1ns / 1ps
`default_nettype none

package tbrl_pkg;

    localparam int ID_W            = 16;
    localparam int LIMIT_W         = 17;
    localparam int USED_W          = 16;
    localparam int KIND_W          = 2;
    localparam int CMP_W           = 17;
    localparam int MAX_RESULTS     = 64;
    localparam int REM_W           = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT = '0;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_GRANT   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_DROP    = 2'd2
    } t_kind;

    typedef enum logic {
        ACT_REQUEST = 1'b0,
        ACT_TICK    = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ,
        ST_QCHK,
        ST_CAP,
        ST_FILL,
        ST_POP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage

`default_nettype wire

FILE: rtl/tbrl_cmp.sv
// Shared compare unit: unsigned less-than and minimum of two operands.
// Depends on tbrl_pkg; the sequencer in the top level multiplexes its operands.
`timescale 1ns / 1ps
`default_nettype none

module tbrl_cmp
    import tbrl_pkg::*;
(
    input  wire logic [CMP_W-1:0] i_a,
    input  wire logic [CMP_W-1:0] i_b,
    output logic                  o_lt,
    output logic [CMP_W-1:0]      o_min
);

    always_comb begin
        o_lt  = (i_a < i_b);
        o_min = o_lt ? i_a : i_b;
    end

endmodule

`default_nettype wire

FILE: rtl/tbrl_queue.sv
// Wait queue of connection ids: circular buffer with one write and one
// registered read port. Depends on tbrl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbrl_queue
    import tbrl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_q_ctrl                     i_ctrl,
    input  wire logic [ID_W-1:0]             i_wr_data,
    output logic      [ID_W-1:0]             o_rd_data,
    output logic      [$clog2(DEPTH+1)-1:0]  o_fill
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rd_data;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [FW-1:0]   r_fill, n_fill;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_ctrl.push) begin
            n_tail = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
            n_fill = r_fill + 1'b1;
        end else if (i_ctrl.pop) begin
            n_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_wr_data;
        end
        if (i_ctrl.pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_fill    = r_fill;

endmodule

`default_nettype wire

FILE: rtl/tick_budget_rate_limiter_unit.sv
// Channel    Dir  Payload                                     Handshake
// s_axis     in   tuser=action, tdata=conn_id,has_client      tvalid/tready
// m_axis     out  tuser=kind, tdata=conn_id_out, tlast=last   tvalid/tready
// apb        in   speed_limit at byte address 0               psel/penable, pready=1
//
// A request passes ST_REQ, then ST_QCHK when the budget is used up, plus any wait
// for the output register. A tick passes ST_CAP and ST_FILL, then ST_POP and ST_EMIT
// per released id, as the shared compare unit and the queue's single read port need.
// Reset is synchronous, active low, and leaves the limit at -1 (unlimited).
// A stalled output holds the sequencer only when it has a new result to load.
`timescale 1ns / 1ps
`default_nettype none

module tick_budget_rate_limiter_unit
    import tbrl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // [15:0] conn_id, [16] has_client
    input  wire logic                  s_axis_tuser,  // [0] action
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata,  // [15:0] conn_id_out
    output logic [KIND_W-1:0]          m_axis_tuser,  // [1:0] kind
    output logic                       m_axis_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    t_state             r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [USED_W-1:0]  r_used;
    logic [REM_W-1:0]   r_rem;
    logic [ID_W-1:0]    r_id;
    logic               r_client;
    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_id;
    t_kind              r_out_kind;
    logic               r_out_last;

    logic               in_acc, out_free, cfg_wr;
    logic [CMP_W-1:0]   cmp_a, cmp_b, cmp_min;
    logic               cmp_lt;
    t_q_ctrl            q_ctrl;
    logic [ID_W-1:0]    q_rd_data;
    logic [FW-1:0]      q_fill;
    logic               out_load, out_last, used_inc, rem_load, rem_dec;
    logic [ID_W-1:0]    out_id;
    t_kind              out_kind;
    logic [REM_W-1:0]   rem_new;
    logic               limit_neg;
    logic [CMP_W-1:0]   budget;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign limit_neg = r_limit[LIMIT_W-1];
    assign budget    = limit_neg ? '0 : CMP_W'(r_limit[LIMIT_W-2:0]);

    tbrl_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_lt  (cmp_lt),
        .o_min (cmp_min)
    );

    tbrl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (q_ctrl),
        .i_wr_data (r_id),
        .o_rd_data (q_rd_data),
        .o_fill    (q_fill)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (s_axis_tuser == ACT_TICK) ? ST_CAP : ST_REQ;
                end
            end
            ST_REQ: begin
                if (!r_client) begin
                    n_state = ST_IDLE;
                end else if (limit_neg || cmp_lt) begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_QCHK;
                end
            end
            ST_QCHK: begin
                if (cmp_lt || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CAP:  n_state = ST_FILL;
            ST_FILL: n_state = (rem_new == '0) ? ST_IDLE : ST_POP;
            ST_POP:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_rem == REM_W'(1)) ? ST_IDLE : ST_POP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control for the current state
    always_comb begin
        cmp_a    = '0;
        cmp_b    = '0;
        q_ctrl   = '0;
        out_load = 1'b0;
        out_id   = r_id;
        out_kind = KIND_GRANT;
        out_last = 1'b1;
        used_inc = 1'b0;
        rem_load = 1'b0;
        rem_dec  = 1'b0;
        rem_new  = REM_W'(cmp_min);
        case (r_state)
            ST_REQ: begin
                cmp_a = CMP_W'(r_used);
                cmp_b = budget;
                if (r_client && (limit_neg || cmp_lt) && out_free) begin
                    out_load = 1'b1;
                    used_inc = !limit_neg;
                end
            end
            ST_QCHK: begin
                cmp_a = CMP_W'(q_fill);
                cmp_b = CMP_W'(QUEUE_DEPTH);
                if (cmp_lt) begin
                    q_ctrl.push = 1'b1;
                end else if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_DROP;
                end
            end
            ST_CAP: begin
                cmp_a    = budget;
                cmp_b    = CMP_W'(MAX_RESULTS);
                rem_load = 1'b1;
            end
            ST_FILL: begin
                cmp_a    = CMP_W'(q_fill);
                cmp_b    = CMP_W'(r_rem);
                rem_load = 1'b1;
            end
            ST_POP: begin
                q_ctrl.pop = 1'b1;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_id   = q_rd_data;
                    out_kind = KIND_RELEASE;
                    out_last = (r_rem == REM_W'(1));
                    used_inc = 1'b1;
                    rem_dec  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_SPEED_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= LIMIT_RESET;
            r_used      <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end
            // A tick restarts the count for the new interval
            if (in_acc && s_axis_tuser == ACT_TICK) begin
                r_used <= '0;
            end else if (used_inc) begin
                r_used <= r_used + 1'b1;
            end
            if (rem_load) begin
                r_rem <= rem_new;
            end else if (rem_dec) begin
                r_rem <= r_rem - 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id     <= s_axis_tdata[ID_W-1:0];
            r_client <= s_axis_tdata[ID_W];
        end
        if (out_load) begin
            r_out_id   <= out_id;
            r_out_kind <= out_kind;
            r_out_last <= out_last;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_id;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_SPEED_LIMIT)
                    ? APB_DATA_W'(signed'(r_limit)) : '0;

endmodule

`default_nettype wire

FILE: rtl/tbrl_checker.sv
// Port-level checks for the tick budget rate limiter, bound to the top level.
// Depends on tbrl_pkg and tick_budget_rate_limiter_unit.
`timescale 1ns / 1ps
`default_nettype none

module tbrl_checker
    import tbrl_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 s_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [KIND_W-1:0]    m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Grants and drops answer a single request, so they always close it
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_GRANT || m_axis_tuser == KIND_DROP)
            |-> m_axis_tlast)
        else $error("grant or drop without tlast");

    // The sequencer is always busy right after it accepts a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after an accepted request");

    // A release starts only after a tick was taken
    a_release_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_REQUEST
            |=> ##1 !(m_axis_tvalid && m_axis_tuser == KIND_RELEASE && !$past(m_axis_tvalid))
                || $past(m_axis_tvalid, 2))
        else $error("release result after a request");

endmodule

bind tick_budget_rate_limiter_unit tbrl_checker u_tbrl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: test/tick_budget_rate_limiter_unit_tb.sv
// Self-checking bench for tick_budget_rate_limiter_unit: directed and random request/tick
// streams against a cycle-free model of the budget, the wait queue and the limit register.
// Depends on tbrl_pkg and the unit RTL only.
`timescale 1ns / 1ps

module tick_budget_rate_limiter_unit_tb;
    import tbrl_pkg::*;

    localparam int QDEPTH        = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_SHOWN     = 10;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_SPEED_LIMIT, 2'b00};

    typedef struct {
        logic [ID_W-1:0] id;
        t_kind           kind;
        logic            last;
    } t_grant;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // model state
    logic signed [LIMIT_W-1:0] limit_model;
    logic [USED_W-1:0]         used_model;
    logic [ID_W-1:0]           waiting_ids[$];
    t_grant                    expected_grants[$];

    int  error_count;
    int  cycle_count;
    bit  gaps_on;
    bit  stalls_on;

    tick_budget_rate_limiter_unit #(
        .QUEUE_DEPTH(QDEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] conn_id, [16] has_client
        .s_axis_tuser  (s_axis_tuser),   // [0] action
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] conn_id_out
        .m_axis_tuser  (m_axis_tuser),   // [1:0] kind
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_error(string what);
        error_count++;
        if (error_count <= MAX_SHOWN) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    function automatic void add_grant(logic [ID_W-1:0] id, t_kind kind, logic last);
        t_grant g;
        g.id   = id;
        g.kind = kind;
        g.last = last;
        expected_grants.insert(expected_grants.size(), g);
    endfunction

    // Compute the results that one accepted request or tick produces.
    function automatic void predict_grants(t_action act, logic [ID_W-1:0] id, logic client);
        int budget;
        int released;
        budget   = (limit_model < 0) ? 0 : int'(limit_model);
        released = 0;
        if (act == ACT_TICK) begin
            used_model = '0;
            while (int'(used_model) < budget && waiting_ids.size() > 0
                   && released < MAX_RESULTS) begin
                add_grant(waiting_ids[0], KIND_RELEASE, 1'b0);
                waiting_ids.delete(0);
                used_model++;
                released++;
            end
            if (released > 0) begin
                expected_grants[expected_grants.size()-1].last = 1'b1;
            end
        end else if (client) begin
            if (limit_model < 0) begin
                add_grant(id, KIND_GRANT, 1'b1);
            end else if (int'(used_model) < budget) begin
                used_model++;
                add_grant(id, KIND_GRANT, 1'b1);
            end else if (waiting_ids.size() >= QDEPTH) begin
                add_grant(id, KIND_DROP, 1'b1);
            end else begin
                waiting_ids.insert(waiting_ids.size(), id);
            end
        end
    endfunction

    task automatic push_event(t_action act, logic [ID_W-1:0] id, logic client);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-ID_W-1){1'b0}}, client, id};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_grants(act, id, client);
    endtask

    task automatic push_request(logic [ID_W-1:0] id, logic client = 1'b1);
        push_event(ACT_REQUEST, id, client);
    endtask

    task automatic push_tick();
        push_event(ACT_TICK, ID_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    endtask

    // Hold off the sender until every expected result has come and the unit is quiet.
    task automatic drain_grants();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_speed_limit(logic signed [LIMIT_W-1:0] value);
        drain_grants();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_model = value;
        // read back through a second transfer
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[LIMIT_W-1:0] !== value) begin
            report_error($sformatf("speed_limit readback: expected %h, got %h",
                                   value, prdata[LIMIT_W-1:0]));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Downstream side: stall a random number of cycles before each result.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = stalls_on ? $urandom_range(0, 6) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_grants.size() == 0) begin
                report_error($sformatf("unexpected result id %h kind %0d last %b",
                                       m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                g = expected_grants[0];
                expected_grants.delete(0);
                if (m_axis_tdata !== g.id || m_axis_tuser !== g.kind
                    || m_axis_tlast !== g.last) begin
                    report_error($sformatf(
                        {"result mismatch: expected id %h kind %0d last %b,",
                         " got id %h kind %0d last %b"},
                        g.id, g.kind, g.last, m_axis_tdata, m_axis_tuser, m_axis_tlast));
                end
            end
        end
    end

    task automatic test_unlimited();
        push_request(16'h0000);
        push_request(16'hFFFF);
        push_request(16'h1234, 1'b0);
        push_tick();
        push_request(16'h8000);
    endtask

    task automatic test_budget_and_queue();
        write_speed_limit(17'sd2);
        push_tick();
        push_request(16'h0A01);
        push_request(16'h0A02);
        push_request(16'h0A03);
        push_request(16'h0A04);
        push_request(16'h0A05, 1'b0);
        push_tick();
        push_request(16'h0A06);
        push_tick();
        push_tick();
    endtask

    task automatic test_limit_change();
        write_speed_limit(17'sd1);
        push_request(16'h5501);
        // used count survives the register write
        write_speed_limit(17'sd3);
        push_request(16'h5502);
        push_request(16'h5503);
        push_request(16'h5504);
        write_speed_limit(-17'sd1);
        push_tick();
        push_request(16'h5505);
        write_speed_limit(17'sd65535);
        push_tick();
    endtask

    task automatic test_queue_overflow();
        write_speed_limit(17'sd0);
        repeat (QDEPTH + 2) push_request(ID_W'($urandom_range(0, 65535)));
        push_tick();
        write_speed_limit(17'sd65535);
        push_tick();
    endtask

    task automatic test_random_traffic();
        logic signed [LIMIT_W-1:0] lim;
        for (int phase = 0; phase < 4; phase++) begin
            case ($urandom_range(0, 6))
                0:       lim = -17'sd1;
                1:       lim = 17'sd0;
                2:       lim = 17'sd1;
                3:       lim = 17'sd2;
                4:       lim = 17'sd65535;
                default: lim = LIMIT_W'($urandom_range(1, 6));
            endcase
            write_speed_limit(lim);
            gaps_on   = (phase != 2);
            stalls_on = (phase != 2);
            for (int n = 0; n < 5; n++) begin
                if (phase == 1 && n == 2) begin
                    drain_grants();
                end
                if ($urandom_range(0, 4) == 0) begin
                    push_tick();
                end else begin
                    push_request(ID_W'($urandom_range(0, 65535)),
                                 $urandom_range(0, 9) != 0);
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        cycle_count   = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        limit_model   = LIMIT_RESET;
        used_model    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_unlimited();
        test_budget_and_queue();
        test_limit_change();
        test_queue_overflow();
        test_random_traffic();

        drain_grants();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: tick_budget_rate_limiter_unit.f
rtl/tbrl_pkg.sv
rtl/tbrl_cmp.sv
rtl/tbrl_queue.sv
rtl/tick_budget_rate_limiter_unit.sv
rtl/tbrl_checker.sv
test/tick_budget_rate_limiter_unit_tb.sv
